FILE: rtl/trbs_pkg.sv
package trbs_pkg;

    // Field widths of one input item and one result item
    localparam int unsigned ADDR_W     = 8;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned MASK_W     = 3;
    localparam int unsigned STAT_W     = 2;
    localparam int unsigned S_TDATA_W  = ADDR_W + DATA_W;
    localparam int unsigned M_FIELDS_W = DATA_W + MASK_W + STAT_W;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    // Entries per copy bank
    localparam int unsigned BANK_DEPTH_DEF = 256;
    localparam int unsigned NUM_COPIES     = 3;

    // Operation carried on tuser
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Erased byte value
    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

    // Vote status codes
    localparam logic [STAT_W-1:0] STATUS_AGREE     = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_CORRECTED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_DIFFERED  = 2'd2;

    // Repair mask bits
    localparam logic [MASK_W-1:0] REPAIR_NONE  = 3'b000;
    localparam logic [MASK_W-1:0] REPAIR_ONE   = 3'b001;
    localparam logic [MASK_W-1:0] REPAIR_TWO   = 3'b010;
    localparam logic [MASK_W-1:0] REPAIR_THREE = 3'b100;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_VOTE  = 3'b100
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;   // write erased byte at sweep counter, advance it
        logic write_all;  // write input byte to all copies, load zero result
        logic rd_issue;   // latch index, read all copies
        logic commit;     // vote, write back repairs, load result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_valid;
    } t_dp_status;

endpackage

FILE: rtl/trbs_ram.sv
module trbs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/trbs_ctrl.sv
module trbs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_op,
    input  logic                  i_out_ready,
    input  trbs_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output trbs_pkg::t_dp_cmd     o_cmd
);

    trbs_pkg::t_state r_state;
    trbs_pkg::t_state n_state;
    logic             w_accept;

    // Take an item only when the result register is free by the next edge
    assign o_in_ready = (r_state == trbs_pkg::ST_IDLE)
                        && (!i_status.out_valid || i_out_ready);
    assign w_accept   = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            trbs_pkg::ST_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_status.clear_last) begin
                    n_state = trbs_pkg::ST_IDLE;
                end
            end
            trbs_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == trbs_pkg::OP_WRITE) begin
                        o_cmd.write_all = 1'b1;
                    end else begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = trbs_pkg::ST_VOTE;
                    end
                end
            end
            trbs_pkg::ST_VOTE: begin
                o_cmd.commit = 1'b1;
                n_state      = trbs_pkg::ST_IDLE;
            end
            default: begin
                n_state = trbs_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trbs_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/trbs_datapath.sv
module trbs_datapath #(
    parameter int unsigned BANK_DEPTH = trbs_pkg::BANK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  trbs_pkg::t_dp_cmd              i_cmd,
    output trbs_pkg::t_dp_status           o_status,
    input  logic [trbs_pkg::ADDR_W-1:0]    i_address,
    input  logic [trbs_pkg::DATA_W-1:0]    i_write_data,
    input  logic                           i_out_ready,
    output logic [trbs_pkg::DATA_W-1:0]    o_read_data,
    output logic [trbs_pkg::MASK_W-1:0]    o_repaired_mask,
    output logic [trbs_pkg::STAT_W-1:0]    o_vote_status
);

    localparam int unsigned AW = $clog2(BANK_DEPTH);
    localparam int unsigned AddrSpan = 1 << trbs_pkg::ADDR_W;

    logic [AW-1:0]                 w_idx;
    logic [AW-1:0]                 r_idx;
    logic [AW-1:0]                 r_clr_cnt;
    logic [AW-1:0]                 w_waddr;
    logic [trbs_pkg::DATA_W-1:0]   w_rdata [trbs_pkg::NUM_COPIES];
    logic [trbs_pkg::NUM_COPIES-1:0] w_we;
    logic [trbs_pkg::DATA_W-1:0]   w_wdata;
    logic [trbs_pkg::DATA_W-1:0]   w_voted;
    logic [trbs_pkg::MASK_W-1:0]   w_mask;
    logic [trbs_pkg::STAT_W-1:0]   w_status;
    logic                          r_out_valid;
    logic [trbs_pkg::DATA_W-1:0]   r_read_data;
    logic [trbs_pkg::MASK_W-1:0]   r_mask;
    logic [trbs_pkg::STAT_W-1:0]   r_status;

    // Fold the byte address into the bank
    if (BANK_DEPTH >= AddrSpan) begin : g_idx_wide
        assign w_idx = AW'(i_address);
    end else begin : g_idx_fold
        logic [AW-1:0] w_fold [AddrSpan];
        for (genvar g = 0; g < AddrSpan; g++) begin : g_fold
            assign w_fold[g] = AW'(g % BANK_DEPTH);
        end
        assign w_idx = w_fold[i_address];
    end

    // Majority vote over the three copies; copy one wins a three-way split
    always_comb begin
        w_voted  = w_rdata[0];
        w_mask   = trbs_pkg::REPAIR_NONE;
        w_status = trbs_pkg::STATUS_AGREE;
        if (w_rdata[0] == w_rdata[1] && w_rdata[1] == w_rdata[2]) begin
            w_voted = w_rdata[0];
        end else if (w_rdata[0] == w_rdata[1]) begin
            w_mask   = trbs_pkg::REPAIR_THREE;
            w_status = trbs_pkg::STATUS_CORRECTED;
        end else if (w_rdata[1] == w_rdata[2]) begin
            w_voted  = w_rdata[1];
            w_mask   = trbs_pkg::REPAIR_ONE;
            w_status = trbs_pkg::STATUS_CORRECTED;
        end else if (w_rdata[0] == w_rdata[2]) begin
            w_mask   = trbs_pkg::REPAIR_TWO;
            w_status = trbs_pkg::STATUS_CORRECTED;
        end else begin
            w_mask   = trbs_pkg::REPAIR_TWO | trbs_pkg::REPAIR_THREE;
            w_status = trbs_pkg::STATUS_DIFFERED;
        end
    end

    always_comb begin
        if (i_cmd.clear_en) begin
            w_waddr = r_clr_cnt;
            w_wdata = trbs_pkg::ERASED_BYTE;
        end else if (i_cmd.commit) begin
            w_waddr = r_idx;
            w_wdata = w_voted;
        end else begin
            w_waddr = w_idx;
            w_wdata = i_write_data;
        end
    end

    for (genvar k = 0; k < trbs_pkg::NUM_COPIES; k++) begin : g_bank
        assign w_we[k] = i_cmd.clear_en || i_cmd.write_all
                         || (i_cmd.commit && w_mask[k]);
        trbs_ram #(
            .WIDTH (trbs_pkg::DATA_W),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we[k]),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_re    (i_cmd.rd_issue),
            .i_raddr (w_idx),
            .o_rdata (w_rdata[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_idx <= w_idx;
        end
        if (i_cmd.commit) begin
            r_read_data <= w_voted;
            r_mask      <= w_mask;
            r_status    <= w_status;
        end else if (i_cmd.write_all) begin
            r_read_data <= '0;
            r_mask      <= trbs_pkg::REPAIR_NONE;
            r_status    <= trbs_pkg::STATUS_AGREE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.commit || i_cmd.write_all) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.clear_last = (r_clr_cnt == AW'(BANK_DEPTH - 1));
    assign o_status.out_valid  = r_out_valid;
    assign o_read_data         = r_read_data;
    assign o_repaired_mask     = r_mask;
    assign o_vote_status       = r_status;

endmodule

FILE: rtl/triple_redundant_byte_store_core.sv
// Byte store held as three copies in three banks of BANK_DEPTH bytes each.
// A write (tuser high) stores the byte at the address in all three banks and
// returns an all-zero result; a new item may follow at once. A read (tuser
// low) fetches the three copies, takes a majority vote, writes the majority
// back over an outvoted copy and returns the voted byte, a mask of rewritten
// copies and a status (0 all agree, 1 one copy corrected, 2 all three
// differed, copy one taken as correct). A read is issued in IDLE and ends in
// VOTE: the banks have a registered read port, so the copies arrive in the
// cycle after the address and are voted and written back there. Addresses
// wrap modulo BANK_DEPTH. After reset the block sweeps every entry of all
// banks to the erased value 0xFF, one entry a cycle, so s_axis_tready stays
// low until the sweep ends. Results sit in an output register, so the next
// item is taken in the cycle the previous result is consumed.
module triple_redundant_byte_store_core #(
    parameter int unsigned BANK_DEPTH = trbs_pkg::BANK_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] address, [15:8] write_data
    input  logic [trbs_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] operation
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] read_data, [10:8] repaired_mask, [12:11] vote_status, rest zero
    output logic [trbs_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

    trbs_pkg::t_dp_cmd              w_cmd;
    trbs_pkg::t_dp_status           w_status;
    logic [trbs_pkg::DATA_W-1:0]    w_read_data;
    logic [trbs_pkg::MASK_W-1:0]    w_repaired_mask;
    logic [trbs_pkg::STAT_W-1:0]    w_vote_status;

    // Sequence the erase sweep, accept items and step reads through the vote
    trbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_op        (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    // Banks, vote and result register
    trbs_datapath #(
        .BANK_DEPTH (BANK_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_address       (s_axis_tdata[trbs_pkg::ADDR_W-1:0]),
        .i_write_data    (s_axis_tdata[trbs_pkg::S_TDATA_W-1:trbs_pkg::ADDR_W]),
        .i_out_ready     (m_axis_tready),
        .o_read_data     (w_read_data),
        .o_repaired_mask (w_repaired_mask),
        .o_vote_status   (w_vote_status)
    );

    assign m_axis_tvalid = w_status.out_valid;
    assign m_axis_tdata  = {{trbs_pkg::M_PAD_W{1'b0}}, w_vote_status,
                            w_repaired_mask, w_read_data};

endmodule

FILE: verif/trbs_store_checker.sv
module trbs_store_checker
    import trbs_pkg::*;
#(
    parameter int unsigned BANK_DEPTH = BANK_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [7:0] address, [15:8] write_data
    input  logic                 i_s_tuser,   // [0] operation
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // [7:0] read_data, [10:8] repaired_mask, [12:11] vote_status, rest zero
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MASK_LO = DATA_W;
    localparam int unsigned STAT_LO = DATA_W + MASK_W;

    typedef struct packed {
        logic [DATA_W-1:0] voted;
        logic [MASK_W-1:0] mask;
        logic [STAT_W-1:0] status;
    } t_vote_result;

    logic [DATA_W-1:0] bank_one   [BANK_DEPTH];
    logic [DATA_W-1:0] bank_two   [BANK_DEPTH];
    logic [DATA_W-1:0] bank_three [BANK_DEPTH];
    t_vote_result      awaited_votes [$];
    int                mismatches = 0;

    // Apply one item to the shadow banks and return the result it yields
    function automatic t_vote_result access_store(input logic op,
                                                  input logic [ADDR_W-1:0] addr,
                                                  input logic [DATA_W-1:0] wdata);
        int unsigned       idx;
        logic [DATA_W-1:0] c1, c2, c3;
        t_vote_result      res;
        idx = addr % BANK_DEPTH;
        res = '{voted: '0, mask: REPAIR_NONE, status: STATUS_AGREE};
        if (op == OP_WRITE) begin
            bank_one[idx]   = wdata;
            bank_two[idx]   = wdata;
            bank_three[idx] = wdata;
            return res;
        end
        c1 = bank_one[idx];
        c2 = bank_two[idx];
        c3 = bank_three[idx];
        if (c1 == c2 && c2 == c3) begin
            res.voted = c1;
        end else if (c1 == c2) begin
            bank_three[idx] = c1;
            res = '{voted: c1, mask: REPAIR_THREE, status: STATUS_CORRECTED};
        end else if (c2 == c3) begin
            bank_one[idx] = c2;
            res = '{voted: c2, mask: REPAIR_ONE, status: STATUS_CORRECTED};
        end else if (c1 == c3) begin
            bank_two[idx] = c1;
            res = '{voted: c1, mask: REPAIR_TWO, status: STATUS_CORRECTED};
        end else begin
            // no majority: copy one wins
            bank_two[idx]   = c1;
            bank_three[idx] = c1;
            res = '{voted: c1, mask: REPAIR_TWO | REPAIR_THREE, status: STATUS_DIFFERED};
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_vote_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < BANK_DEPTH; i++) begin
                bank_one[i]   = ERASED_BYTE;
                bank_two[i]   = ERASED_BYTE;
                bank_three[i] = ERASED_BYTE;
            end
            awaited_votes.delete();
        end else begin
            // results first: a result never belongs to the item taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (awaited_votes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result tdata=%h", $realtime, i_m_tdata);
                end else begin
                    want = awaited_votes.pop_front();
                    if (i_m_tdata[DATA_W-1:0] !== want.voted
                        || i_m_tdata[STAT_LO-1:MASK_LO] !== want.mask
                        || i_m_tdata[M_FIELDS_W-1:STAT_LO] !== want.status
                        || i_m_tdata[M_TDATA_W-1:M_FIELDS_W] !== '0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp data=%h mask=%b status=%0d pad=0, got %s",
                                     $realtime, want.voted, want.mask, want.status,
                                     $sformatf("data=%h mask=%b status=%0d pad=%b",
                                               i_m_tdata[DATA_W-1:0],
                                               i_m_tdata[STAT_LO-1:MASK_LO],
                                               i_m_tdata[M_FIELDS_W-1:STAT_LO],
                                               i_m_tdata[M_TDATA_W-1:M_FIELDS_W]));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_votes.push_back(access_store(i_s_tuser, i_s_tdata[ADDR_W-1:0],
                                                     i_s_tdata[S_TDATA_W-1:ADDR_W]));
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_votes.size();
    end

endmodule

FILE: verif/tb_triple_redundant_byte_store_core.sv
module tb_triple_redundant_byte_store_core;
    timeunit 1ns;
    timeprecision 1ps;

    import trbs_pkg::*;

    // Cycles with no item moving on either side before the run is abandoned.
    // Covers the post-reset sweep of every bank entry with ample margin.
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1850;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // [7:0] address, [15:8] write_data
    logic                 s_axis_tuser  = OP_READ;   // [0] operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [7:0] read_data, [10:8] repaired_mask, [12:11] vote_status, rest zero
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int   fail_count;
    int   votes_pending;
    int   idle_cycles   = 0;
    logic steady        = 1'b0;   // high: neither side idles

    triple_redundant_byte_store_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    trbs_store_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (votes_pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: drop tready in roughly 7 percent of cycles, never while steady
    always @(negedge i_clk) begin
        m_axis_tready = steady ? 1'b1 : ($urandom_range(0, 99) >= 7);
    end

    // Watchdog: abandon the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one item, called at a falling edge; return at the falling edge after it
    // was taken. tvalid stays high into the next item unless a gap is drawn.
    task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
        while (!steady && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = S_TDATA_W'($urandom);   // scribble over the bus while idle
            s_axis_tuser  = 1'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {wdata, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    initial begin
        int                sent;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;

        // Hold reset, then release it; the block then sweeps its banks on its own
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Erased entries read back before any write
        send_item(OP_READ,  8'h00, 8'h00);
        send_item(OP_READ,  8'hFF, 8'h00);
        send_item(OP_READ,  8'h5A, 8'hFF);
        // Extremes of address and data, then read them back
        send_item(OP_WRITE, 8'h00, 8'h00);
        send_item(OP_WRITE, 8'hFF, 8'hFF);
        send_item(OP_WRITE, 8'h80, 8'hAA);
        send_item(OP_WRITE, 8'h7F, 8'h55);
        send_item(OP_READ,  8'h00, 8'hFF);
        send_item(OP_READ,  8'hFF, 8'h00);
        send_item(OP_READ,  8'h80, 8'h00);
        send_item(OP_READ,  8'h7F, 8'h00);
        // Single set bits, then read straight after write on the same entry
        send_item(OP_WRITE, 8'h01, 8'h80);
        send_item(OP_READ,  8'h01, 8'h00);
        send_item(OP_WRITE, 8'hFE, 8'h01);
        send_item(OP_READ,  8'hFE, 8'h00);
        // Overwrite, then read twice so a clean entry is voted again
        send_item(OP_WRITE, 8'h01, 8'h3C);
        send_item(OP_READ,  8'h01, 8'h00);
        send_item(OP_READ,  8'h01, 8'h00);
        send_item(OP_WRITE, 8'h00, 8'hFF);
        send_item(OP_READ,  8'h00, 8'h00);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // Stretch with no idling on either side
            steady = (sent >= 700 && sent < 1000);
            // Once, hold the sender until every result has come back
            if (sent >= 1200 && sent < 1203) begin
                s_axis_tvalid = 1'b0;
                while (votes_pending != 0) @(negedge i_clk);
                sent = 1203;
            end
            // Mostly a small pool of entries so reads hit written data
            case ($urandom_range(0, 9))
                0:       addr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                1, 2:    addr = ADDR_W'($urandom);
                default: addr = ADDR_W'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 7))
                0:       wdata = 8'h00;
                1:       wdata = 8'hFF;
                default: wdata = DATA_W'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0) begin
                // write then read back the same entry at once
                send_item(OP_WRITE, addr, wdata);
                send_item(OP_READ, addr, DATA_W'($urandom));
                sent += 2;
            end else begin
                send_item($urandom_range(0, 1) ? OP_WRITE : OP_READ, addr, wdata);
                sent++;
            end
        end
        steady        = 1'b0;
        s_axis_tvalid = 1'b0;

        // Drain, then wait for anything stray to surface
        while (votes_pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
